// File: hw/rtl/prs_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the parallax row scroll tile streamer.
// Used by every module of the block; depends on nothing else.
package prs_pkg;

	localparam int ROWS_DEF    = 32;
	localparam int PLANE_TILES = 64;
	localparam int IMAGE_TILES = 160;
	localparam int FRAC_BITS   = 10;

	localparam int ROW_W    = 5;
	localparam int SPEED_W  = 14;
	localparam int COL_W    = 6;
	localparam int SRC_W    = 8;
	localparam int MROW_W   = 6;
	localparam int SCROLL_W = 10;
	localparam int PIX_W    = 9;
	localparam int OFFSET_W = PIX_W + FRAC_BITS;
	localparam int PADDR_W  = 3;

	// Register index taken from paddr[2].
	localparam logic REG_START_ROW = 1'b0;
	localparam logic [ROW_W-1:0] START_ROW_RESET = 5'd3;

	// Result kinds.
	localparam logic KIND_COPY   = 1'b0;
	localparam logic KIND_SCROLL = 1'b1;

	// One queued item: a row in range, its speed and its plane tile row.
	typedef struct packed {
		logic [ROW_W-1:0]   row;
		logic [SPEED_W-1:0] speed;
		logic [MROW_W-1:0]  map_row;
	} item_t;

	// Per-row state held in the row memory.
	typedef struct packed {
		logic [OFFSET_W-1:0] offset;
		logic [COL_W-1:0]    dcol;
		logic [SRC_W-1:0]    scol;
	} row_state_t;

	localparam row_state_t ROW_STATE_RESET = '{
		offset: '0,
		dcol:   COL_W'(PLANE_TILES - 1),
		scol:   SRC_W'(PLANE_TILES - 1)
	};

endpackage

// File: hw/rtl/prs_front.sv
`timescale 1ns / 1ps
// Front end: accepts input beats, drops rows outside the table and stamps the
// plane tile row. Depends on prs_pkg.
module prs_front #(
	parameter int ROWS = prs_pkg::ROWS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [prs_pkg::ROW_W-1:0]     start_row,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [prs_pkg::ROW_W-1:0]     row_index,
	input  logic [prs_pkg::SPEED_W-1:0]   speed,
	output logic                          push_valid,
	input  logic                          push_ready,
	output prs_pkg::item_t                push_item
);

	logic           vld_s1;
	prs_pkg::item_t item_s1;
	logic           in_range;

	assign in_range   = {2'b00, row_index} < 7'(ROWS);
	assign in_ready   = !vld_s1 || push_ready;
	assign push_valid = vld_s1;
	assign push_item  = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			vld_s1 <= in_range;
		end else if (push_ready) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.row     <= row_index;
			item_s1.speed   <= speed;
			item_s1.map_row <= prs_pkg::MROW_W'(start_row) + prs_pkg::MROW_W'(row_index);
		end
	end

endmodule

// File: hw/rtl/prs_queue.sv
`timescale 1ns / 1ps
// Two-entry queue between the front end and the row sequencer.
// Depends on prs_pkg for the item type.
module prs_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  prs_pkg::item_t push_item,
	output logic           pop_valid,
	input  logic           pop,
	output prs_pkg::item_t pop_item
);

	prs_pkg::item_t slot_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;
	logic           do_push;
	logic           do_pop;

	assign push_ready = count_q != 2'd2;
	assign pop_valid  = count_q != 2'd0;
	assign pop_item   = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// File: hw/rtl/prs_back.sv
`timescale 1ns / 1ps
// Row sequencer: per-row state memory, offset update, copy command run and
// the closing scroll beat through an output register. Depends on prs_pkg.
module prs_back #(
	parameter int ROWS = prs_pkg::ROWS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               pop_valid,
	output logic                               pop,
	input  prs_pkg::item_t                     pop_item,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               kind,
	output logic [prs_pkg::COL_W-1:0]          dest_col,
	output logic [prs_pkg::SRC_W-1:0]          source_col,
	output logic [prs_pkg::MROW_W-1:0]         map_row,
	output logic signed [prs_pkg::SCROLL_W-1:0] scroll_value,
	output logic                               last
);

	localparam int IDX_W = (ROWS > 1) ? $clog2(ROWS) : 1;

	typedef enum logic [1:0] {ST_IDLE, ST_CALC, ST_COPY, ST_SCROLL} state_t;

	state_t                          state_q;
	prs_pkg::row_state_t             mem_q [ROWS];
	logic [ROWS-1:0]                 vld_q;
	prs_pkg::row_state_t             rd_q;
	logic                            rd_vld_q;
	prs_pkg::item_t                  item_q;
	logic [IDX_W-1:0]                idx_q;
	logic [prs_pkg::COL_W-1:0]       td_q;
	logic [prs_pkg::SRC_W-1:0]       ts_q;
	logic [prs_pkg::COL_W-1:0]       cnt_q;
	logic [prs_pkg::PIX_W-1:0]       ipix_q;

	logic                            out_valid_q;
	logic                            kind_q;
	logic [prs_pkg::COL_W-1:0]       dest_q;
	logic [prs_pkg::SRC_W-1:0]       src_q;
	logic [prs_pkg::MROW_W-1:0]      mrow_q;
	logic [prs_pkg::SCROLL_W-1:0]    scroll_q;
	logic                            last_q;

	logic                            load;
	logic [IDX_W-1:0]                pop_idx;
	logic [6:0]                      row_ext;
	prs_pkg::row_state_t             cur;
	logic [prs_pkg::OFFSET_W:0]      sum;
	logic [prs_pkg::OFFSET_W-1:0]    new_off;
	logic [prs_pkg::PIX_W-1:0]       ipix;
	logic [prs_pkg::COL_W-1:0]       dst;
	logic [prs_pkg::COL_W-1:0]       width;
	logic                            do_copy;
	logic [prs_pkg::SRC_W:0]         src_sum;
	logic [prs_pkg::SRC_W-1:0]       src_end;
	logic [prs_pkg::SRC_W-1:0]       cur_src_next;
	logic [prs_pkg::SRC_W-1:0]       ts_next;
	prs_pkg::row_state_t             wr_entry;

	function automatic logic [prs_pkg::SRC_W-1:0] src_inc(input logic [prs_pkg::SRC_W-1:0] s);
		if (s >= prs_pkg::SRC_W'(prs_pkg::IMAGE_TILES - 1)) begin
			return '0;
		end
		return s + 1'b1;
	endfunction

	assign load    = !out_valid_q || out_ready;
	assign pop     = pop_valid && ((state_q == ST_IDLE) || (state_q == ST_SCROLL && load));
	assign row_ext = {2'b00, pop_item.row};
	assign pop_idx = row_ext[IDX_W-1:0];

	// New offset and tile column bookkeeping for the row just read.
	always_comb begin
		cur     = rd_vld_q ? rd_q : prs_pkg::ROW_STATE_RESET;
		sum     = {1'b0, cur.offset} + (prs_pkg::OFFSET_W + 1)'(item_q.speed);
		new_off = sum[prs_pkg::OFFSET_W] ? '0 : sum[prs_pkg::OFFSET_W-1:0];
		ipix    = new_off[prs_pkg::OFFSET_W-1:prs_pkg::FRAC_BITS];
		dst     = ipix[prs_pkg::PIX_W-1:3] - 1'b1;
		width   = dst - cur.dcol;
		do_copy = (ipix[2:0] == 3'd0) && (dst != cur.dcol);
		src_sum = {1'b0, cur.scol} + (prs_pkg::SRC_W + 1)'(width);
		if (src_sum >= (prs_pkg::SRC_W + 1)'(prs_pkg::IMAGE_TILES)) begin
			src_sum = src_sum - (prs_pkg::SRC_W + 1)'(prs_pkg::IMAGE_TILES);
		end
		src_end         = src_sum[prs_pkg::SRC_W-1:0];
		cur_src_next    = src_inc(cur.scol);
		ts_next         = src_inc(ts_q);
		wr_entry.offset = new_off;
		wr_entry.dcol   = do_copy ? dst : cur.dcol;
		wr_entry.scol   = do_copy ? src_end : cur.scol;
	end

	// Row memory: one read on pop, one write when the row is updated.
	always_ff @(posedge clk) begin
		if (pop) begin
			rd_q <= mem_q[pop_idx];
		end
		if (state_q == ST_CALC) begin
			mem_q[idx_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			vld_q       <= '0;
			rd_vld_q    <= 1'b0;
			out_valid_q <= 1'b0;
			item_q      <= '0;
			idx_q       <= '0;
			td_q        <= '0;
			ts_q        <= '0;
			cnt_q       <= '0;
			ipix_q      <= '0;
			kind_q      <= prs_pkg::KIND_COPY;
			dest_q      <= '0;
			src_q       <= '0;
			mrow_q      <= '0;
			scroll_q    <= '0;
			last_q      <= 1'b0;
		end else begin
			if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (pop) begin
				item_q   <= pop_item;
				idx_q    <= pop_idx;
				rd_vld_q <= vld_q[pop_idx];
			end
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						state_q <= ST_CALC;
					end
				end
				ST_CALC: begin
					vld_q[idx_q] <= 1'b1;
					td_q         <= cur.dcol + 1'b1;
					ts_q         <= cur_src_next;
					cnt_q        <= width;
					ipix_q       <= ipix;
					state_q      <= do_copy ? ST_COPY : ST_SCROLL;
				end
				ST_COPY: begin
					if (load) begin
						out_valid_q <= 1'b1;
						kind_q      <= prs_pkg::KIND_COPY;
						dest_q      <= td_q;
						src_q       <= ts_q;
						mrow_q      <= item_q.map_row;
						scroll_q    <= '0;
						last_q      <= 1'b0;
						td_q        <= td_q + 1'b1;
						ts_q        <= ts_next;
						cnt_q       <= cnt_q - 1'b1;
						if (cnt_q == prs_pkg::COL_W'(1)) begin
							state_q <= ST_SCROLL;
						end
					end
				end
				ST_SCROLL: begin
					if (load) begin
						out_valid_q <= 1'b1;
						kind_q      <= prs_pkg::KIND_SCROLL;
						dest_q      <= '0;
						src_q       <= '0;
						mrow_q      <= item_q.map_row;
						scroll_q    <= '0 - {1'b0, ipix_q};
						last_q      <= 1'b1;
						state_q     <= pop ? ST_CALC : ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = kind_q;
	assign dest_col     = dest_q;
	assign source_col   = src_q;
	assign map_row      = mrow_q;
	assign scroll_value = scroll_q;
	assign last         = last_q;

	a_copy_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_COPY |-> cnt_q != '0)
		else $error("copy run entered with nothing left to copy");

	a_copy_src: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && kind_q == prs_pkg::KIND_COPY |->
		src_q < prs_pkg::SRC_W'(prs_pkg::IMAGE_TILES) && !last_q)
		else $error("copy beat with bad image column or end flag");

	a_pop_gap: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> state_q == ST_CALC)
		else $error("row read not followed by its update");

	a_scroll_end: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCROLL && load |=> out_valid_q && last_q)
		else $error("scroll beat missing after item");

endmodule

// File: hw/rtl/parallax_row_scroll_tile_streamer_unit.sv
`timescale 1ns / 1ps
// Top level of the parallax row scroll tile streamer: configuration register,
// front end, queue and row sequencer. Depends on prs_pkg, prs_front,
// prs_queue and prs_back.
//
//  Port group   Direction   Handshake                Payload
//  input        in          in_valid / in_ready      row_index, speed
//  output       out         out_valid / out_ready    kind, dest_col, source_col,
//                                                    map_row, scroll_value, last
//  config       in/out      psel, penable, pready    paddr, pwdata, prdata
//
// Each item passes the sequencer as a row update, any copy beats and a scroll beat;
// back to back, the scroll beat overlaps the next read, else the read is made in idle.
// The front end and a two-entry queue keep taking items while the sequencer works.
// Reset clears the row valid bits, so every row starts at offset 0 with its
// columns at 63; no clearing pass is needed. A stalled output holds the
// sequencer, which in turn backs up the queue and the input.
module parallax_row_scroll_tile_streamer_unit #(
	parameter int ROWS = prs_pkg::ROWS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [prs_pkg::PADDR_W-1:0]          paddr,
	input  logic [31:0]                          pwdata,
	output logic [31:0]                          prdata,
	output logic                                 pready,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [prs_pkg::ROW_W-1:0]            row_index,
	input  logic [prs_pkg::SPEED_W-1:0]          speed,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 kind,
	output logic [prs_pkg::COL_W-1:0]            dest_col,
	output logic [prs_pkg::SRC_W-1:0]            source_col,
	output logic [prs_pkg::MROW_W-1:0]           map_row,
	output logic signed [prs_pkg::SCROLL_W-1:0]  scroll_value,
	output logic                                 last
);

	logic [prs_pkg::ROW_W-1:0] start_row_q;
	logic                      push_valid;
	logic                      push_ready;
	prs_pkg::item_t            push_item;
	logic                      pop_valid;
	logic                      pop;
	prs_pkg::item_t            pop_item;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == prs_pkg::REG_START_ROW) ? 32'(start_row_q) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_row_q <= prs_pkg::START_ROW_RESET;
		end else if (psel && penable && pwrite && paddr[2] == prs_pkg::REG_START_ROW) begin
			start_row_q <= pwdata[prs_pkg::ROW_W-1:0];
		end
	end

	prs_front #(.ROWS(ROWS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start_row  (start_row_q),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.row_index  (row_index),
		.speed      (speed),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	prs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop        (pop),
		.pop_item   (pop_item)
	);

	prs_back #(.ROWS(ROWS)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.pop_valid    (pop_valid),
		.pop          (pop),
		.pop_item     (pop_item),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.kind         (kind),
		.dest_col     (dest_col),
		.source_col   (source_col),
		.map_row      (map_row),
		.scroll_value (scroll_value),
		.last         (last)
	);

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench of the parallax row scroll tile streamer: directed rows, then
// randomized scroll sequences under random idling, checked beat by beat against a predictor.
// Depends on prs_pkg and parallax_row_scroll_tile_streamer_unit only.
module testbench;

	localparam int ROWS_DEF    = prs_pkg::ROWS_DEF;
	localparam int PLANE_TILES = prs_pkg::PLANE_TILES;
	localparam int IMAGE_TILES = prs_pkg::IMAGE_TILES;
	localparam int FRAC_BITS   = prs_pkg::FRAC_BITS;
	localparam int ROW_W       = prs_pkg::ROW_W;
	localparam int SPEED_W     = prs_pkg::SPEED_W;
	localparam int COL_W       = prs_pkg::COL_W;
	localparam int SRC_W       = prs_pkg::SRC_W;
	localparam int MROW_W      = prs_pkg::MROW_W;
	localparam int SCROLL_W    = prs_pkg::SCROLL_W;
	localparam int PIX_W       = prs_pkg::PIX_W;
	localparam int OFFSET_W    = prs_pkg::OFFSET_W;
	localparam int PADDR_W     = prs_pkg::PADDR_W;
	localparam logic REG_START_ROW = prs_pkg::REG_START_ROW;
	localparam logic KIND_COPY     = prs_pkg::KIND_COPY;
	localparam logic KIND_SCROLL   = prs_pkg::KIND_SCROLL;
	localparam logic [ROW_W-1:0] START_ROW_RESET = prs_pkg::START_ROW_RESET;

	localparam int ACC_W = OFFSET_W + 1;
	localparam logic [ACC_W-1:0] OFFSET_LIMIT = ACC_W'((PLANE_TILES * 8) << FRAC_BITS);
	localparam logic [PADDR_W-1:0] ADDR_START_ROW = {REG_START_ROW, 2'b00};
	localparam logic [PADDR_W-1:0] ADDR_SPARE     = {~REG_START_ROW, 2'b00};
	localparam int IDLE_LIMIT  = 5000;
	localparam int MAX_REPORTS = 10;
	localparam int SETTLE      = 8;

	typedef struct packed {
		logic                kind;
		logic [COL_W-1:0]    dest_col;
		logic [SRC_W-1:0]    source_col;
		logic [MROW_W-1:0]   map_row;
		logic [SCROLL_W-1:0] scroll_value;
		logic                last;
	} beat_t;

	// One directed row; typed rows carry their own expected beats.
	typedef struct packed {
		logic [ROW_W-1:0]    row;
		logic [SPEED_W-1:0]  speed;
		logic                typed;
		logic                has_copy;
		logic [COL_W-1:0]    dest_col;
		logic [SRC_W-1:0]    source_col;
		logic [SCROLL_W-1:0] scroll_value;
	} stim_row_t;

	logic                       clk;
	logic                       arst_n     = 1'b0;
	logic                       psel       = 1'b0;
	logic                       penable    = 1'b0;
	logic                       pwrite     = 1'b0;
	logic [PADDR_W-1:0]         paddr      = '0;
	logic [31:0]                pwdata     = '0;
	logic [31:0]                prdata;
	logic                       pready;
	logic                       in_valid   = 1'b0;
	logic                       in_ready;
	logic [ROW_W-1:0]           row_index  = '0;
	logic [SPEED_W-1:0]         speed      = '0;
	logic                       out_valid;
	logic                       out_ready  = 1'b0;
	logic                       kind;
	logic [COL_W-1:0]           dest_col;
	logic [SRC_W-1:0]           source_col;
	logic [MROW_W-1:0]          map_row;
	logic signed [SCROLL_W-1:0] scroll_value;
	logic                       last;

	// Predictor state: per-row offset and last written columns, plus the register.
	logic [ACC_W-1:0] row_offset [ROWS_DEF];
	logic [COL_W-1:0] row_dest   [ROWS_DEF];
	logic [SRC_W-1:0] row_source [ROWS_DEF];
	logic [ROW_W-1:0] start_row_q;

	beat_t     expected_beats[$];
	beat_t     item_beats[$];
	stim_row_t directed_rows[$];
	beat_t     seen_beat, wanted_beat;

	int  err_count   = 0;
	int  idle_cycles = 0;
	int  stall_left  = 0;
	int  items_sent  = 0;
	int  beats_seen  = 0;
	int  copies_seen = 0;
	int  copy_run    = 0;
	int  longest_run = 0;
	int  sweeps_left = 0;
	bit  in_calm     = 1'b0;
	bit  out_calm    = 1'b0;

	parallax_row_scroll_tile_streamer_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready), .row_index(row_index), .speed(speed),
		.out_valid(out_valid), .out_ready(out_ready), .kind(kind), .dest_col(dest_col),
		.source_col(source_col), .map_row(map_row), .scroll_value(scroll_value),
		.last(last)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic void note_error(input string msg);
		err_count++;
		if (err_count <= MAX_REPORTS)
			$display("%s", msg);
	endfunction

	// Mostly no gap, often a short one, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Advances one row by one frame and leaves the beats it causes in item_beats.
	task automatic advance_row(input logic [ROW_W-1:0] row, input logic [SPEED_W-1:0] spd);
		logic [ACC_W-1:0]    ofs;
		logic [PIX_W-1:0]    pix;
		logic [COL_W-1:0]    dst, td, run;
		logic [SRC_W-1:0]    ts;
		logic [MROW_W-1:0]   mrow;
		logic [SCROLL_W-1:0] neg;
		beat_t               b;
		item_beats.delete();
		mrow = MROW_W'(start_row_q) + MROW_W'(row);
		ofs = row_offset[row] + ACC_W'(spd);
		if (ofs >= OFFSET_LIMIT)
			ofs = '0;
		row_offset[row] = ofs;
		pix = PIX_W'(ofs >> FRAC_BITS);
		// The column just left of the offset's tile; the plane is 64 tiles wide,
		// so six-bit arithmetic wraps it for free.
		dst = COL_W'(pix >> 3) - COL_W'(1);
		if (pix[2:0] == 3'd0 && dst != row_dest[row]) begin
			run = dst - row_dest[row];
			td = row_dest[row];
			ts = row_source[row];
			for (int i = 0; i < run; i++) begin
				td = td + COL_W'(1);
				ts = (ts >= SRC_W'(IMAGE_TILES - 1)) ? '0 : ts + SRC_W'(1);
				b = '{KIND_COPY, td, ts, mrow, '0, 1'b0};
				item_beats.push_back(b);
			end
			row_dest[row] = td;
			row_source[row] = ts;
		end
		neg = '0 - SCROLL_W'(pix);
		b = '{KIND_SCROLL, '0, '0, mrow, neg, 1'b1};
		item_beats.push_back(b);
	endtask

	// Presents one beat on the input side, after a random gap, and waits for it to go in.
	task automatic send_item(input logic [ROW_W-1:0] row, input logic [SPEED_W-1:0] spd);
		int gap;
		gap = in_calm ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		row_index <= row;
		speed <= spd;
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	task automatic feed_row(input logic [ROW_W-1:0] row, input logic [SPEED_W-1:0] spd);
		send_item(row, spd);
		advance_row(row, spd);
		foreach (item_beats[i])
			expected_beats.push_back(item_beats[i]);
	endtask

	// Holds the input back until every expected beat has come out.
	task automatic drain(input int settle);
		in_valid <= 1'b0;
		while (expected_beats.size() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == ADDR_START_ROW)
			start_row_q = data[ROW_W-1:0];
		@(posedge clk);
	endtask

	task automatic check_start_row();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= ADDR_START_ROW;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== 32'(start_row_q))
			note_error($sformatf("start_row read: expected %0d, got %0d",
				start_row_q, prdata));
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// A write to the unused address must leave start_row alone.
	task automatic set_start_row(input logic [ROW_W-1:0] value);
		write_reg(ADDR_START_ROW, {$urandom} & ~32'(2**ROW_W - 1) | 32'(value));
		write_reg(ADDR_SPARE, $urandom);
		check_start_row();
	endtask

	task automatic run_random(input int budget);
		int left, len, px, pattern;
		logic [ROW_W-1:0] row;
		left = budget;
		sweeps_left = 1;
		while (left > 0) begin
			pattern = $urandom_range(0, 9);
			// Most bursts stay on a few rows so each row builds up a long history.
			if ($urandom_range(0, 9) < 7)
				row = ROW_W'($urandom_range(4, 7));
			else
				row = ROW_W'($urandom_range(0, ROWS_DEF - 1));
			in_calm = ($urandom_range(0, 3) == 0);
			out_calm = ($urandom_range(0, 3) == 0);
			if (pattern == 0 && sweeps_left > 0) begin
				// At the top speed the offset lands on a tile boundary only now and then
				// and wraps within the run, which gives copy runs across most of the plane.
				sweeps_left--;
				repeat (34) feed_row(row, SPEED_W'(2**SPEED_W - 1));
				left -= 34;
			end else if (pattern < 7) begin
				// Whole-pixel speeds hit tile boundaries often.
				len = $urandom_range(2, 12);
				px = $urandom_range(0, 15);
				repeat (len) begin
					if ($urandom_range(0, 3) == 0)
						px = $urandom_range(0, 15);
					feed_row(row, SPEED_W'(px << FRAC_BITS));
				end
				left -= len;
			end else begin
				len = $urandom_range(1, 6);
				repeat (len)
					feed_row(ROW_W'($urandom_range(0, ROWS_DEF - 1)),
						SPEED_W'($urandom_range(0, 2**SPEED_W - 1)));
				left -= len;
			end
		end
		in_calm = 1'b0;
		out_calm = 1'b0;
	endtask

	always @(posedge clk) begin
		if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			out_ready <= 1'b1;
			if (!out_calm)
				stall_left <= pick_gap();
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (out_valid && out_ready) begin
				seen_beat = '{kind, dest_col, source_col, map_row, scroll_value, last};
				beats_seen++;
				if (seen_beat.kind == KIND_COPY) begin
					copies_seen++;
					copy_run++;
				end else begin
					if (copy_run > longest_run)
						longest_run = copy_run;
					copy_run = 0;
				end
				if (expected_beats.size() == 0) begin
					note_error($sformatf("Unexpected beat %0d: kind %0d dest %0d src %0d",
						beats_seen, kind, dest_col, source_col));
				end else begin
					wanted_beat = expected_beats.pop_front();
					if (seen_beat.kind !== wanted_beat.kind
						|| seen_beat.dest_col !== wanted_beat.dest_col
						|| seen_beat.source_col !== wanted_beat.source_col
						|| seen_beat.map_row !== wanted_beat.map_row
						|| seen_beat.scroll_value !== wanted_beat.scroll_value
						|| seen_beat.last !== wanted_beat.last)
						note_error($sformatf({"Beat %0d mismatch: expected kind %0d dest %0d ",
							"src %0d row %0d scroll %0d last %0d, got kind %0d dest %0d ",
							"src %0d row %0d scroll %0d last %0d"}, beats_seen,
							wanted_beat.kind, wanted_beat.dest_col, wanted_beat.source_col,
							wanted_beat.map_row, $signed(wanted_beat.scroll_value),
							wanted_beat.last, seen_beat.kind, seen_beat.dest_col,
							seen_beat.source_col, seen_beat.map_row,
							$signed(seen_beat.scroll_value), seen_beat.last));
				end
			end
		end
	end

	initial begin
		wait (arst_n === 1'b1);
		while (idle_cycles < IDLE_LIMIT)
			@(posedge clk);
		$display("Watchdog: no beat moved for %0d cycles", IDLE_LIMIT);
		$display("Verification failed");
		$finish;
	end

	initial begin
		stim_row_t        cur;
		beat_t            b;
		logic [MROW_W-1:0] mrow;
		for (int r = 0; r < ROWS_DEF; r++) begin
			row_offset[r] = '0;
			row_dest[r] = COL_W'(PLANE_TILES - 1);
			row_source[r] = SRC_W'(PLANE_TILES - 1);
		end
		start_row_q = START_ROW_RESET;

		// Typed rows: still frame on a boundary, top speed without a boundary, single
		// copies on a fresh row, a sub-tile step, and a boundary with the column unchanged.
		directed_rows.push_back('{5'd0,  14'd0,     1'b1, 1'b0, 6'd0, 8'd0,  SCROLL_W'(0)});
		directed_rows.push_back('{5'd31, 14'd16383, 1'b1, 1'b0, 6'd0, 8'd0,  SCROLL_W'(-15)});
		directed_rows.push_back('{5'd1,  14'd8192,  1'b1, 1'b1, 6'd0, 8'd64, SCROLL_W'(-8)});
		directed_rows.push_back('{5'd1,  14'd8192,  1'b1, 1'b1, 6'd1, 8'd65, SCROLL_W'(-16)});
		directed_rows.push_back('{5'd2,  14'd1024,  1'b1, 1'b0, 6'd0, 8'd0,  SCROLL_W'(-1)});
		directed_rows.push_back('{5'd2,  14'd7168,  1'b1, 1'b1, 6'd0, 8'd64, SCROLL_W'(-8)});
		directed_rows.push_back('{5'd1,  14'd0,     1'b1, 1'b0, 6'd0, 8'd0,  SCROLL_W'(-16)});
		// Predicted rows: multi-column runs and fractional speeds.
		directed_rows.push_back('{5'd3,  14'd12288, 1'b0, 1'b0, 6'd0, 8'd0, '0});
		directed_rows.push_back('{5'd3,  14'd12288, 1'b0, 1'b0, 6'd0, 8'd0, '0});
		directed_rows.push_back('{5'd3,  14'd16383, 1'b0, 1'b0, 6'd0, 8'd0, '0});
		repeat (4)
			directed_rows.push_back('{5'd16, 14'd10240, 1'b0, 1'b0, 6'd0, 8'd0, '0});
		directed_rows.push_back('{5'd31, 14'd16383, 1'b0, 1'b0, 6'd0, 8'd0, '0});
		directed_rows.push_back('{5'd8,  14'd15360, 1'b0, 1'b0, 6'd0, 8'd0, '0});
		directed_rows.push_back('{5'd8,  14'd15360, 1'b0, 1'b0, 6'd0, 8'd0, '0});
		directed_rows.push_back('{5'd0,  14'd16383, 1'b0, 1'b0, 6'd0, 8'd0, '0});
		directed_rows.push_back('{5'd2,  14'h2AAA,  1'b0, 1'b0, 6'd0, 8'd0, '0});
		directed_rows.push_back('{5'd2,  14'h1555,  1'b0, 1'b0, 6'd0, 8'd0, '0});

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		check_start_row();

		foreach (directed_rows[i]) begin
			cur = directed_rows[i];
			send_item(cur.row, cur.speed);
			advance_row(cur.row, cur.speed);
			if (cur.typed) begin
				mrow = MROW_W'(start_row_q) + MROW_W'(cur.row);
				if (cur.has_copy) begin
					b = '{KIND_COPY, cur.dest_col, cur.source_col, mrow, '0, 1'b0};
					expected_beats.push_back(b);
				end
				b = '{KIND_SCROLL, '0, '0, mrow, cur.scroll_value, 1'b1};
				expected_beats.push_back(b);
			end else begin
				foreach (item_beats[j])
					expected_beats.push_back(item_beats[j]);
			end
		end
		drain(SETTLE);

		set_start_row(ROW_W'(2**ROW_W - 1));
		run_random(83);
		drain(SETTLE);
		set_start_row('0);
		run_random(83);
		drain(SETTLE);
		set_start_row(ROW_W'($urandom_range(1, 2**ROW_W - 2)));
		run_random(83);
		drain(3 * SETTLE);

		foreach (expected_beats[i])
			note_error($sformatf("Expected beat never came: kind %0d dest %0d src %0d",
				expected_beats[i].kind, expected_beats[i].dest_col,
				expected_beats[i].source_col));

		$display("Sent %0d row updates; checked %0d result beats, %0d of them tile copies.",
			items_sent, beats_seen, copies_seen);
		$display("Longest copy run was %0d beats, over four start_row settings.", longest_run);
		if (err_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
